[hw/rtl/hec_pkg.sv]
`default_nettype none

package hec_pkg;

  // Field widths of the codec
  localparam int unsigned MaxDataBits = 57;
  localparam int unsigned CheckBits   = 6;
  localparam int unsigned CodeBits    = 63;
  localparam int unsigned LenBits     = 6;

  // Stream packing
  localparam int unsigned InDataBits  = 120;
  localparam int unsigned OutDataBits = 72;

  // Register reset value
  localparam logic [LenBits-1:0] DataLenReset = 6'd4;

  // Command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef logic [CodeBits-1:0] word_t;

  // Per-beat control that travels down the pipe
  typedef struct packed {
    logic               cmd;
    logic [LenBits-1:0] len;
  } ctl_t;

  // Code length for a data length: clamp to 1..57, then least check count
  function automatic logic [LenBits-1:0] code_len(logic [LenBits-1:0] dlen);
    logic [6:0] k;
    logic [6:0] r;
    k = {1'b0, dlen};
    if (k < 7'd1) k = 7'd1;
    if (k > 7'(MaxDataBits)) k = 7'(MaxDataBits);
    r = 7'd1;
    for (int i = 1; i < CheckBits; i++) begin
      if ((7'd1 << r) < (k + r + 7'd1)) r = r + 7'd1;
    end
    return LenBits'(k + r);
  endfunction

  // Spread data bits over the positions that are not powers of two
  function automatic word_t scatter(logic [MaxDataBits-1:0] d);
    word_t w;
    int    j;
    w = '0;
    j = 0;
    for (int p = 1; p <= CodeBits; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = d[j];
        j++;
      end
    end
    return w;
  endfunction

  // Positions whose index has bit i set
  function automatic word_t group_mask(int i);
    word_t m;
    m = '0;
    for (int p = 1; p <= CodeBits; p++) begin
      m[p-1] = ((p >> i) & 1) != 0;
    end
    return m;
  endfunction

  // Mask of the low len positions
  function automatic word_t len_mask(logic [LenBits-1:0] len);
    logic [CodeBits:0] m;
    m = ({{CodeBits{1'b0}}, 1'b1} << len) - {{CodeBits{1'b0}}, 1'b1};
    return m[CodeBits-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hec_build.sv]
`default_nettype none

module hec_build (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             cmd_i,
  input  wire logic [hec_pkg::MaxDataBits-1:0]  data_i,
  input  wire hec_pkg::word_t                   code_i,
  input  wire logic [hec_pkg::LenBits-1:0]      len_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output hec_pkg::ctl_t                         ctl_o,
  output hec_pkg::word_t                        word_o
);
  import hec_pkg::*;

  logic   valid_q;
  ctl_t   ctl_q;
  word_t  word_d, word_q;

  // Load when empty or when the next stage takes the held beat
  assign in_ready_o = !valid_q || out_ready_i;

  // Place data bits or take the received word, cut to the code length
  always_comb begin
    if (cmd_i == CMD_DECODE) begin
      word_d = code_i & len_mask(len_i);
    end else begin
      word_d = scatter(data_i) & len_mask(len_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ctl_q.cmd <= cmd_i;
      ctl_q.len <= len_i;
      word_q    <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign ctl_o       = ctl_q;
  assign word_o      = word_q;

endmodule

`default_nettype wire

[hw/rtl/hec_parity.sv]
`default_nettype none

module hec_parity (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire hec_pkg::ctl_t                 ctl_i,
  input  wire hec_pkg::word_t                word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output hec_pkg::ctl_t                      ctl_o,
  output hec_pkg::word_t                     word_o,
  output logic [hec_pkg::CheckBits-1:0]      par_o
);
  import hec_pkg::*;

  logic                 valid_q;
  ctl_t                 ctl_q;
  word_t                word_q;
  logic [CheckBits-1:0] par_d, par_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // One even-parity tree per check group
  always_comb begin
    for (int i = 0; i < CheckBits; i++) begin
      par_d[i] = ^(word_i & group_mask(i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ctl_q  <= ctl_i;
      word_q <= word_i;
      par_q  <= par_d;
    end
  end

  assign out_valid_o = valid_q;
  assign ctl_o       = ctl_q;
  assign word_o      = word_q;
  assign par_o       = par_q;

endmodule

`default_nettype wire

[hw/rtl/hec_fix.sv]
`default_nettype none

module hec_fix (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire hec_pkg::ctl_t                 ctl_i,
  input  wire hec_pkg::word_t                word_i,
  input  wire logic [hec_pkg::CheckBits-1:0] par_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output hec_pkg::word_t                     code_o,
  output logic [hec_pkg::CheckBits-1:0]      syndrome_o,
  output logic                               fixed_o,
  output logic                               beyond_o
);
  import hec_pkg::*;

  logic                 valid_q;
  word_t                code_d, code_q;
  logic [CheckBits-1:0] syn_d, syn_q;
  logic                 fixed_d, fixed_q;
  logic                 beyond_d, beyond_q;
  word_t                checks;
  word_t                flip;

  assign in_ready_o = !valid_q || out_ready_i;

  // Check bits at the power-of-two positions
  always_comb begin
    checks = '0;
    for (int i = 0; i < CheckBits; i++) begin
      checks[(1 << i) - 1] = par_i[i];
    end
  end

  // Encode: add check bits. Decode: flip the bit the syndrome names, or flag a syndrome past the code length.
  always_comb begin
    flip     = '0;
    syn_d    = '0;
    fixed_d  = 1'b0;
    beyond_d = 1'b0;
    code_d   = word_i | checks;
    if (ctl_i.cmd == CMD_DECODE) begin
      syn_d = par_i;
      if (par_i != '0) begin
        if (par_i > ctl_i.len) begin
          beyond_d = 1'b1;
        end else begin
          fixed_d = 1'b1;
          flip    = word_t'(1) << (par_i - CheckBits'(1));
        end
      end
      code_d = word_i ^ flip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      code_q   <= code_d;
      syn_q    <= syn_d;
      fixed_q  <= fixed_d;
      beyond_q <= beyond_d;
    end
  end

  assign out_valid_o = valid_q;
  assign code_o      = code_q;
  assign syndrome_o  = syn_q;
  assign fixed_o     = fixed_q;
  assign beyond_o    = beyond_q;

endmodule

`default_nettype wire

[hw/rtl/hamming_encode_correct.sv]
// Throughput: one beat per cycle while the master side accepts; three register
// stages (place, parity, correct) each hold one beat and advance whenever the
// stage after them frees up.
// Reset: all stage valid bits clear and data_len returns to 4 (code length 7).
`default_nettype none

module hamming_encode_correct (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration: data_len
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [hec_pkg::LenBits-1:0]       cfg_data_i,
  // Input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [hec_pkg::InDataBits-1:0]    s_axis_tdata,  // data_word, code_in
  input  wire logic                              s_axis_tuser,  // command
  // Output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [hec_pkg::OutDataBits-1:0]        m_axis_tdata   // code_out, syndrome,
                                                                // error_fixed, beyond_code
);
  import hec_pkg::*;

  logic [LenBits-1:0]   len_q;
  logic                 b_valid, b_ready;
  ctl_t                 b_ctl;
  word_t                b_word;
  logic                 p_valid, p_ready;
  ctl_t                 p_ctl;
  word_t                p_word;
  logic [CheckBits-1:0] p_par;
  word_t                code_out;
  logic [CheckBits-1:0] syndrome;
  logic                 error_fixed;
  logic                 beyond_code;

  // Keep the code length derived from data_len
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= code_len(DataLenReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= code_len(cfg_data_i);
    end
  end

  hec_build u_build (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .data_i      (s_axis_tdata[MaxDataBits-1:0]),
    .code_i      (s_axis_tdata[MaxDataBits+CodeBits-1:MaxDataBits]),
    .len_i       (len_q),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .ctl_o       (b_ctl),
    .word_o      (b_word)
  );

  hec_parity u_parity (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .ctl_i       (b_ctl),
    .word_i      (b_word),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .ctl_o       (p_ctl),
    .word_o      (p_word),
    .par_o       (p_par)
  );

  hec_fix u_fix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .ctl_i       (p_ctl),
    .word_i      (p_word),
    .par_i       (p_par),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .code_o      (code_out),
    .syndrome_o  (syndrome),
    .fixed_o     (error_fixed),
    .beyond_o    (beyond_code)
  );

  // Pack the result beat
  assign m_axis_tdata = {1'b0, beyond_code, error_fixed, syndrome, code_out};

endmodule

`default_nettype wire

[hw/rtl/hec_checker.sv]
`default_nettype none

module hec_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Input side stalls only when a result is waiting
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // A correction and an out-of-range syndrome exclude each other
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[69] && m_axis_tdata[70]))
    else $error("error_fixed and beyond_code both set");

  // Either flag needs a nonzero syndrome
  a_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[69] || m_axis_tdata[70]) |->
      m_axis_tdata[68:63] != 6'd0)
    else $error("flag set with zero syndrome");

endmodule

bind hamming_encode_correct hec_checker u_hec_checker (.*);

`default_nettype wire

[test/hamming_encode_correct_tb.sv]
`default_nettype none

module hamming_encode_correct_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hec_pkg::*;

  // Expected outcome of one beat, fields named as they leave the block
  typedef struct packed {
    logic               beyond;
    logic               fixed;
    logic [LenBits-1:0] syn;
    word_t              code;
  } outcome_t;

  // Track the data length, predict each codeword and check what comes out
  class hamming_ledger;
    logic [LenBits-1:0] data_len;
    outcome_t           pending[$];
    int unsigned        errors;
    int unsigned        n_encode;
    int unsigned        n_decode;
    int unsigned        n_fixed;
    int unsigned        n_beyond;

    function new();
      data_len = DataLenReset;
      errors   = 0;
      n_encode = 0;
      n_decode = 0;
      n_fixed  = 0;
      n_beyond = 0;
    endfunction

    // Code length after clamping the data length to 1..57
    function int unsigned code_len();
      int unsigned k;
      int unsigned r;
      k = data_len;
      if (k < 1) k = 1;
      if (k > MaxDataBits) k = MaxDataBits;
      r = 1;
      while (r < CheckBits && (1 << r) < k + r + 1) r++;
      return k + r;
    endfunction

    // Even parity over positions 1..len whose index has bit i set
    function bit group_parity(word_t c, int unsigned len, int unsigned i);
      bit acc;
      acc = 1'b0;
      for (int unsigned p = 1; p <= len; p++) begin
        if (((p >> i) & 1) != 0) acc ^= c[p-1];
      end
      return acc;
    endfunction

    function outcome_t predict(logic cmd, logic [MaxDataBits-1:0] dw, word_t cw);
      outcome_t    o;
      int unsigned len;
      int unsigned r;
      int unsigned j;
      o   = '0;
      len = code_len();
      r   = $clog2(len + 1);
      if (cmd == CMD_ENCODE) begin
        // Place data bits on the non-power-of-two positions, then set check bits
        j = 0;
        for (int unsigned p = 1; p <= len; p++) begin
          if ((p & (p - 1)) != 0) begin
            o.code[p-1] = dw[j];
            j++;
          end
        end
        for (int unsigned i = 0; i < r; i++) begin
          if (group_parity(o.code, len, i)) o.code[(1 << i) - 1] = 1'b1;
        end
      end else begin
        o.code = cw & word_t'((64'd1 << len) - 64'd1);
        for (int unsigned i = 0; i < r; i++) o.syn[i] = group_parity(o.code, len, i);
        if (o.syn != '0) begin
          if (o.syn > len) begin
            o.beyond = 1'b1;
          end else begin
            o.code[o.syn-1] = ~o.code[o.syn-1];
            o.fixed = 1'b1;
          end
        end
      end
      return o;
    endfunction

    function void note_item(logic cmd, logic [MaxDataBits-1:0] dw, word_t cw);
      pending.push_back(predict(cmd, dw, cw));
      if (cmd == CMD_ENCODE) n_encode++;
      else n_decode++;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 30) $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_result(logic [OutDataBits-1:0] beat);
      outcome_t want;
      if (pending.size() == 0) begin
        report($sformatf("result beat %h with no pending item", beat));
        return;
      end
      want = pending.pop_front();
      if (beat[62:0] != want.code)
        report($sformatf("code_out %h, want %h", beat[62:0], want.code));
      if (beat[68:63] != want.syn)
        report($sformatf("syndrome %0d, want %0d", beat[68:63], want.syn));
      if (beat[69] != want.fixed)
        report($sformatf("error_fixed %b, want %b", beat[69], want.fixed));
      if (beat[70] != want.beyond)
        report($sformatf("beyond_code %b, want %b", beat[70], want.beyond));
      if (want.fixed) n_fixed++;
      if (want.beyond) n_beyond++;
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [LenBits-1:0]      cfg_data_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataBits-1:0]   s_axis_tdata = '0;  // data_word, code_in
  logic                    s_axis_tuser = 1'b0;  // command
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataBits-1:0]  m_axis_tdata;  // code_out, syndrome, error_fixed, beyond_code

  hamming_ledger ledger;
  int unsigned   sender_idle_pct = 0;
  int unsigned   receiver_stall_pct = 0;

  // Data lengths to visit; the first is the reset value and is not written
  logic [LenBits-1:0] len_plan [10] = '{6'd4, 6'd57, 6'd2, 6'd0, 6'd63,
                                        6'd1, 6'd58, 6'd26, 6'd11, 6'd4};

  hamming_encode_correct dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Check every result beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) ledger.check_result(m_axis_tdata);
  end

  // Present one beat after a random gap and hold it until accepted
  task automatic send_word(logic cmd, logic [MaxDataBits-1:0] dw, word_t cw);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {cw, dw};
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_item(cmd, dw, cw);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted codeword has come out
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_data_len(logic [LenBits-1:0] value);
    hold_until_drained();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.data_len = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Field extremes, both commands, and a syndrome that can land past the code
  task automatic send_corner_words();
    word_t top_err;
    top_err = ledger.predict(CMD_ENCODE, '1, '0).code;
    top_err[ledger.code_len() - 1] = ~top_err[ledger.code_len() - 1];
    send_word(CMD_ENCODE, '0, '1);
    send_word(CMD_ENCODE, '1, '0);
    send_word(CMD_DECODE, '1, '0);
    send_word(CMD_DECODE, '0, '1);
    send_word(CMD_DECODE, '0, word_t'(63'h0A));
    send_word(CMD_DECODE, '0, top_err);
  endtask

  // Random encodes, valid codewords with zero, one or two flipped bits, and raw noise decodes
  task automatic send_random();
    logic [MaxDataBits-1:0] d;
    word_t                  c;
    int unsigned            pick;
    int unsigned            flips;
    int unsigned            len;
    d    = MaxDataBits'({$urandom(), $urandom()});
    c    = CodeBits'({$urandom(), $urandom()});
    pick = $urandom_range(99);
    len  = ledger.code_len();
    if (pick < 35) begin
      send_word(CMD_ENCODE, d, c);
    end else if (pick < 80) begin
      c     = ledger.predict(CMD_ENCODE, d, '0).code;
      flips = $urandom_range(3);
      if (flips == 3) flips = 2;
      for (int unsigned f = 0; f < flips; f++) begin
        pick    = $urandom_range(len - 1);
        c[pick] = ~c[pick];
      end
      send_word(CMD_DECODE, MaxDataBits'($urandom()), c);
    end else begin
      send_word(CMD_DECODE, d, c);
    end
  endtask

  initial begin
    ledger = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (len_plan[s]) begin
      if (s != 0) write_data_len(len_plan[s]);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      if (s < 3) send_corner_words();
      // Sweep the idling mixes: none, sender only, receiver only, both
      for (int m = 0; m < 4; m++) begin
        sender_idle_pct    = (m == 1) ? 62 : (m == 3) ? 38 : 0;
        receiver_stall_pct = (m == 2) ? 62 : (m == 3) ? 38 : 0;
        for (int n = 0; n < 46; n++) send_random();
        if (m == 1) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (6) @(posedge clk_i);

    $display("checked %0d beats: %0d encodes, %0d decodes", ledger.n_encode + ledger.n_decode,
             ledger.n_encode, ledger.n_decode);
    $display("decodes fixed %0d single-bit errors and flagged %0d out-of-range syndromes",
             ledger.n_fixed, ledger.n_beyond);
    if (ledger.errors == 0) begin
      $display("hamming_encode_correct regression: pass");
    end else begin
      $display("hamming_encode_correct regression: fail");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("hamming_encode_correct regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
